// ===== sv/chs_pkg.sv =====
// chs_pkg: constants, widths and the arctangent table for the hemisphere sampler.
// No dependencies.
`default_nettype none
package chs_pkg;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 32;
	localparam int IN_W    = 16;
	localparam int XY_W    = 18;
	localparam int Z_W     = 17;
	localparam int DENS_W  = 15;
	localparam logic [31:0] GAIN_Q31   = 32'h4DBA76D4;
	localparam logic [31:0] INV_PI_Q32 = 32'h517CC1B7;
	localparam int ONE_Q16     = 65536;
	localparam int DENSITY_MAX = 20861;
	// quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// atan(2^-i) in binary angle units, full turn = 2^32
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		unique case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

// ===== sv/chs_if.sv =====
// chs_if: valid/ready channel interface carrying a payload of width W.
// No dependencies.
`default_nettype none
interface chs_if #(parameter int W = 32) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/chs_root_cell.sv =====
// chs_root_cell: one step of a bit-by-bit integer square root, registered.
// No dependencies - stand-alone arithmetic cell.
`default_nettype none
module chs_root_cell #(
	parameter int W    = 64,
	parameter int STEP = 0
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] n_in,
	input  wire logic [W-1:0] root_in,
	output logic [W-1:0]      n_s1,
	output logic [W-1:0]      root_s1
);
	localparam int SH = W - 2 - 2 * STEP;
	logic [W-1:0] bit_c, trial;

	// compare remainder against root + bit, then shift the root
	always_comb begin
		bit_c = {{(W-1){1'b0}}, 1'b1} << SH;
		trial = root_in + bit_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_in >= trial) begin
				n_s1    <= n_in - trial;
				root_s1 <= (root_in >> 1) + bit_c;
			end else begin
				n_s1    <= n_in;
				root_s1 <= root_in >> 1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/chs_cordic_cell.sv =====
// chs_cordic_cell: one rotation-mode CORDIC micro-rotation, registered.
// Depends on chs_pkg for the arctangent table.
`default_nettype none
module chs_cordic_cell #(
	parameter int W    = 40,
	parameter int STEP = 0
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [W-1:0] x_in,
	input  wire logic signed [W-1:0] y_in,
	input  wire logic signed [33:0]  ang_in,
	output logic signed [W-1:0]      x_s1,
	output logic signed [W-1:0]      y_s1,
	output logic signed [33:0]       ang_s1
);
	import chs_pkg::*;
	localparam logic signed [33:0] ATAN = $signed({2'b00, atan_turn(STEP)});
	logic signed [W-1:0] dx, dy;

	always_comb begin
		dx = y_in >>> STEP;
		dy = x_in >>> STEP;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ang_in[33]) begin
				x_s1   <= x_in - dx;
				y_s1   <= y_in + dy;
				ang_s1 <= ang_in - ATAN;
			end else begin
				x_s1   <= x_in + dx;
				y_s1   <= y_in - dy;
				ang_s1 <= ang_in + ATAN;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/cosine_hemisphere_sampler.sv =====
// cosine_hemisphere_sampler: top level, root and CORDIC cell chains plus output stage.
// Depends on chs_pkg, chs_if, chs_root_cell, chs_cordic_cell.
`default_nettype none
// Takes one (sample_u, sample_v) beat per cycle unless the sink stalls, and returns
// one direction beat per input, in order. Each beat passes the square-root chain
// of FRAC_BITS + 1 root cells, the gain multiply register, the chain of
// CORDIC_STAGES (capped at 32) CORDIC cells, the fold with density multiply, and
// the round and saturate into the output register; every cell takes a new beat
// each cycle the pipeline advances. The whole pipeline advances only when the
// output register is free or being taken, so a stalled sink stalls it with no loss.
module cosine_hemisphere_sampler #(
	parameter int FRAC_BITS     = chs_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = chs_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chs_if.sink       in_ch,
	chs_if.source     out_ch
);
	import chs_pkg::*;
	localparam int NS    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int RW    = 2 * FRAC_BITS + 2;  // root operand width (even)
	localparam int RSTEP = FRAC_BITS + 1;      // root iterations
	localparam int CW    = FRAC_BITS + 4;      // CORDIC datapath width
	localparam int LAT   = RSTEP + 1 + NS + 1;
	localparam int ZW    = FRAC_BITS + 2;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic out_vld_q;

	assign adv          = !out_vld_q || out_ch.ready;
	assign in_ch.ready  = adv;
	assign out_ch.valid = out_vld_q;

	// valid bits travel along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[LAT-2:0], in_ch.valid};
			out_vld_q <= vld_q[LAT-1];
		end
	end

	// input formatting
	logic [IN_W-1:0] u_in, v_in;
	logic [FRAC_BITS:0] vf, rv;
	assign u_in = in_ch.data[2*IN_W-1:IN_W];
	assign v_in = in_ch.data[IN_W-1:0];
	always_comb begin
		if (FRAC_BITS >= IN_W)
			vf = (FRAC_BITS+1)'({v_in} << (FRAC_BITS - IN_W));
		else
			vf = (FRAC_BITS+1)'(v_in >> (IN_W - FRAC_BITS));
		rv = ((FRAC_BITS+1)'(1) << FRAC_BITS) - vf;
	end
	logic [1:0]  q_in;
	logic [15:0] usum;
	logic signed [33:0] ang_in;
	assign usum   = u_in + 16'h2000;
	assign q_in   = usum[15:14];
	assign ang_in = ($signed({20'd0, usum[13:0]}) - 34'sh2000) <<< 16;

	// square-root cell chains for z and radius; quadrant and angle ride alongside
	logic [RW-1:0] zn [RSTEP+1], zr [RSTEP+1], rn [RSTEP+1], rr [RSTEP+1];
	logic [1:0]    qr [RSTEP+1];
	logic signed [33:0] ar [RSTEP+1];
	assign zn[0] = RW'(vf) << FRAC_BITS;
	assign rn[0] = RW'(rv) << FRAC_BITS;
	assign zr[0] = '0;
	assign rr[0] = '0;
	assign qr[0] = q_in;
	assign ar[0] = ang_in;
	for (genvar i = 0; i < RSTEP; i++) begin : g_root
		chs_root_cell #(.W(RW), .STEP(i)) u_z (
			.clk(clk), .en(adv), .n_in(zn[i]), .root_in(zr[i]),
			.n_s1(zn[i+1]), .root_s1(zr[i+1]));
		chs_root_cell #(.W(RW), .STEP(i)) u_r (
			.clk(clk), .en(adv), .n_in(rn[i]), .root_in(rr[i]),
			.n_s1(rn[i+1]), .root_s1(rr[i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				qr[i+1] <= qr[i];
				ar[i+1] <= ar[i];
			end
		end
	end

	// gain pre-scale of the radius, round half up
	logic signed [CW-1:0] x0_s1;
	logic [ZW-1:0] z_s1;
	logic [1:0] q_s1;
	logic signed [33:0] a_s1;
	logic [FRAC_BITS+32:0] gprod;
	assign gprod = (FRAC_BITS+33)'(rr[RSTEP][FRAC_BITS:0]) * (FRAC_BITS+33)'(GAIN_Q31)
		+ ((FRAC_BITS+33)'(1) << 30);
	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s1 <= $signed(CW'(gprod >> 31));
			z_s1  <= ZW'(zr[RSTEP]);
			q_s1  <= qr[RSTEP];
			a_s1  <= ar[RSTEP];
		end
	end

	// CORDIC cell chain
	logic signed [CW-1:0] cx [NS+1], cy [NS+1];
	logic signed [33:0] ca [NS+1];
	logic [ZW-1:0] cz [NS+1];
	logic [1:0] cq [NS+1];
	assign cx[0] = x0_s1;
	assign cy[0] = '0;
	assign ca[0] = a_s1;
	assign cz[0] = z_s1;
	assign cq[0] = q_s1;
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		chs_cordic_cell #(.W(CW), .STEP(i)) u_c (
			.clk(clk), .en(adv), .x_in(cx[i]), .y_in(cy[i]), .ang_in(ca[i]),
			.x_s1(cx[i+1]), .y_s1(cy[i+1]), .ang_s1(ca[i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				cz[i+1] <= cz[i];
				cq[i+1] <= cq[i];
			end
		end
	end

	// quadrant fold; density multiply
	logic signed [CW:0] fx_s2, fy_s2;
	logic [ZW-1:0] z_s2;
	logic [ZW+32:0] dprod_s2;
	logic signed [CW:0] ex, ey;
	assign ex = (CW+1)'(cx[NS]);
	assign ey = (CW+1)'(cy[NS]);
	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (cq[NS])
				QUAD_0: begin fx_s2 <= ex;  fy_s2 <= ey;  end
				QUAD_1: begin fx_s2 <= -ey; fy_s2 <= ex;  end
				QUAD_2: begin fx_s2 <= -ex; fy_s2 <= -ey; end
				default: begin fx_s2 <= ey; fy_s2 <= -ex; end
			endcase
			z_s2     <= cz[NS];
			dprod_s2 <= (ZW+33)'(cz[NS]) * (ZW+33)'(INV_PI_Q32)
				+ ((ZW+33)'(1) << 31);
		end
	end

	// convert to Q.16 with round half up, then saturate
	function automatic logic signed [CW+17:0] to_q16(input logic signed [CW+1:0] v);
		logic signed [CW+17:0] w;
		w = (CW+18)'(v);
		if (FRAC_BITS > 16)
			return (w + ((CW+18)'(1) << (FRAC_BITS - 17))) >>> (FRAC_BITS - 16);
		return w <<< (16 - FRAC_BITS);
	endfunction
	function automatic logic signed [CW+17:0] sat(input logic signed [CW+17:0] v,
		input logic signed [CW+17:0] lo, input logic signed [CW+17:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	localparam logic signed [CW+17:0] P1  = (CW+18)'(ONE_Q16);
	localparam logic signed [CW+17:0] N1  = -(CW+18)'(ONE_Q16);
	localparam logic signed [CW+17:0] DMX = (CW+18)'(DENSITY_MAX);
	logic signed [CW+17:0] ox, oy, oz, od;
	always_comb begin
		ox = sat(to_q16((CW+2)'(fx_s2)), N1, P1);
		oy = sat(to_q16((CW+2)'(fy_s2)), N1, P1);
		oz = sat(to_q16($signed((CW+2)'(z_s2))), '0, P1);
		od = sat(to_q16($signed((CW+2)'(dprod_s2 >> 32))), '0, DMX);
	end

	logic [XY_W-1:0] ox_q, oy_q;
	logic [Z_W-1:0] oz_q;
	logic [DENS_W-1:0] od_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			ox_q <= XY_W'(ox);
			oy_q <= XY_W'(oy);
			oz_q <= Z_W'(oz);
			od_q <= DENS_W'(od);
		end
	end
	assign out_ch.data = {ox_q, oy_q, oz_q, od_q};
endmodule
`default_nettype wire

// ===== sv/chs_checker.sv =====
// chs_checker: port-level checks on the hemisphere sampler, bound to the top level.
// Depends on cosine_hemisphere_sampler, into which it is bound.
`default_nettype none
module chs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [67:0] out_data
);
	// output beat stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	// ready is high whenever the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
	// z never exceeds one
	a_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data[31:15] <= 17'd65536)
		else $error("dir_z out of range");
	// density bound
	a_d: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data[14:0] <= 15'd20861)
		else $error("density out of range");
endmodule

bind cosine_hemisphere_sampler chs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
